@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("pfa assertion failed");

// next-cycle implication
`define PFA_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("pfa assertion failed");

`endif

@@ rtl/pfa_pkg.sv @@
package pfa_pkg;

	localparam int FRAME_SLOTS   = 64;
	localparam int PROCESS_SLOTS = 16;
	localparam int FIDX_W        = $clog2(FRAME_SLOTS);
	localparam int PID_W         = $clog2(PROCESS_SLOTS);
	localparam int CNT_W         = FIDX_W + 1;
	localparam int LIST_DEPTH    = PROCESS_SLOTS * FRAME_SLOTS;
	localparam int DIV_STEPS     = 31;

	localparam logic [6:0] FRAMES_RESET = 7'd64;
	localparam logic [6:0] THRESH_RESET = 7'd8;

	// input kinds
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_ACCESS = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// configuration register indexes
	localparam logic CFG_FRAMES = 1'b0;
	localparam logic CFG_THRESH = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  process_id;
		logic [6:0]  pages;
		logic [6:0]  roll;
		logic [30:0] random_pick;
	} in_item_t;

	typedef struct packed {
		logic [6:0]  granted_pages;
		logic        fault;
		logic [31:0] process_fault_count;
		logic [31:0] total_fault_count;
		logic [6:0]  free_frame_count;
		logic [6:0]  owned_frame_count;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_ACCESS = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [PID_W-1:0] pid;
		logic [6:0]       pages;
		logic             faulty;
		logic [30:0]      draw;
	} cmd_t;

endpackage

@@ rtl/pfa_ram.sv @@
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/pfa_front.sv @@
module pfa_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pfa_pkg::in_item_t in_item,
	input  logic [6:0]       thresh,
	output logic             cmd_valid,
	output pfa_pkg::cmd_t    cmd,
	input  logic             cmd_pop
);
	import pfa_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push, pop;

	always_comb begin
		cls.pid    = in_item.process_id;
		cls.pages  = in_item.pages;
		cls.faulty = in_item.roll < thresh;
		cls.draw   = in_item.random_pick;
		unique case (in_item.kind)
			KIND_ALLOC:  cls.op = OP_ALLOC;
			KIND_FREE:   cls.op = OP_FREE;
			KIND_ACCESS: cls.op = OP_ACCESS;
			KIND_NONE:   cls.op = OP_NOP;
		endcase
	end

	assign in_stall  = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = mem_q[rd_q];
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ rtl/pfa_div.sv @@
module pfa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] dividend,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic [6:0]  rem
);
	import pfa_pkg::*;

	logic        busy_q, done_q;
	logic [4:0]  step_q;
	logic [30:0] num_q;
	logic [6:0]  div_q;
	logic [7:0]  rem_q;
	logic [7:0]  trial;

	// restoring remainder, one dividend bit a cycle
	assign trial = {rem_q[6:0], num_q[30]};
	assign done  = done_q;
	assign rem   = rem_q[6:0];

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[29:0], 1'b0};
			rem_q <= (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'(DIV_STEPS - 1);
			end else if (busy_q) begin
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 5'd1;
				end
			end
		end
	end
endmodule

@@ rtl/pfa_back.sv @@
module pfa_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  pfa_pkg::cmd_t     cmd,
	output logic              cmd_pop,
	input  logic [6:0]        frames_cfg,
	input  logic              pool_clear,
	output logic              out_valid,
	output pfa_pkg::out_item_t out_item,
	input  logic              out_stall
);
	import pfa_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_DISP   = 16'h0002,
		S_GSTART = 16'h0004,
		S_FSCAN  = 16'h0008,
		S_ERD    = 16'h0010,
		S_ECK    = 16'h0020,
		S_LRD    = 16'h0040,
		S_LCK    = 16'h0080,
		S_TOWR   = 16'h0100,
		S_TAKE   = 16'h0200,
		S_FRD    = 16'h0400,
		S_FCK    = 16'h0800,
		S_DIV    = 16'h1000,
		S_AREL   = 16'h2000,
		S_AMV    = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	localparam int LIST_AW = PID_W + FIDX_W;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [6:0]        rem_q, granted_q;
	logic              fault_q, evict_q;
	logic [CNT_W-1:0]  idx_q, k_q, used_q;
	logic [PID_W-1:0]  v_q;
	logic [FRAME_SLOTS-1:0] valid_q;
	logic [CNT_W-1:0]  cnt_q [PROCESS_SLOTS];
	logic [31:0]       pf_q [PROCESS_SLOTS];
	logic [31:0]       tf_q;

	logic [CNT_W-1:0]  tot, cnt_sel, cnt_dec;
	logic [PID_W-1:0]  cnt_addr;
	logic              g_end, g_ok;

	logic               list_we;
	logic [LIST_AW-1:0] list_waddr, list_raddr;
	logic [FIDX_W-1:0]  list_wdata, list_rdata;
	logic               owner_we;
	logic [PID_W-1:0]   owner_rdata;
	logic [FIDX_W-1:0]  fr;

	logic              div_start, div_done;
	logic [6:0]        div_rem;
	logic              out_load;

	assign tot = (frames_cfg > 7'(FRAME_SLOTS)) ? CNT_W'(FRAME_SLOTS) : CNT_W'(frames_cfg);
	assign cnt_addr = (state_q == S_LRD || state_q == S_LCK) ? v_q : cmd_q.pid;
	assign cnt_sel  = cnt_q[cnt_addr];
	assign cnt_dec  = cnt_sel - CNT_W'(1);
	assign fr       = list_rdata;

	assign g_ok  = (state_q == S_TAKE) && (cnt_sel < CNT_W'(FRAME_SLOTS));
	assign g_end = (state_q == S_TAKE) ||
		((state_q == S_FSCAN || state_q == S_ERD) && idx_q >= tot);

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign div_start = (state_q == S_DISP) && (cmd_q.op == OP_ACCESS) &&
		(cnt_sel != '0) && cmd_q.faulty;
	assign out_load  = (state_q == S_DONE) && (!out_valid || !out_stall);
	assign owner_we  = g_ok;

	always_comb begin
		list_raddr = {cmd_q.pid, k_q[FIDX_W-1:0]};
		list_we    = 1'b0;
		list_waddr = {cmd_q.pid, k_q[FIDX_W-1:0]};
		list_wdata = list_rdata;
		unique case (state_q)
			S_LRD:  list_raddr = {v_q, k_q[FIDX_W-1:0]};
			S_LCK:  list_raddr = {v_q, cnt_dec[FIDX_W-1:0]};
			S_DIV:  list_raddr = {cmd_q.pid, div_rem[FIDX_W-1:0]};
			S_AREL: list_raddr = {cmd_q.pid, cnt_dec[FIDX_W-1:0]};
			S_TOWR: begin
				list_we    = 1'b1;
				list_waddr = {v_q, k_q[FIDX_W-1:0]};
			end
			S_AMV:  list_we = 1'b1;
			S_TAKE: begin
				list_we    = g_ok;
				list_waddr = {cmd_q.pid, cnt_sel[FIDX_W-1:0]};
				list_wdata = idx_q[FIDX_W-1:0];
			end
			default: ;
		endcase
	end

	pfa_ram #(.WIDTH(FIDX_W), .DEPTH(LIST_DEPTH)) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	pfa_ram #(.WIDTH(PID_W), .DEPTH(FRAME_SLOTS)) u_owner (
		.clk   (clk),
		.we    (owner_we),
		.waddr (idx_q[FIDX_W-1:0]),
		.wdata (cmd_q.pid),
		.raddr (idx_q[FIDX_W-1:0]),
		.rdata (owner_rdata)
	);

	pfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd_q.draw),
		.divisor  (cnt_sel),
		.done     (div_done),
		.rem      (div_rem)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (out_load) begin
			out_item.granted_pages       <= granted_q;
			out_item.fault               <= fault_q;
			out_item.process_fault_count <= pf_q[cmd_q.pid];
			out_item.total_fault_count   <= tf_q;
			out_item.free_frame_count    <= (used_q < tot) ? tot - used_q : '0;
			out_item.owned_frame_count   <= cnt_sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			rem_q     <= '0;
			granted_q <= '0;
			fault_q   <= 1'b0;
			evict_q   <= 1'b0;
			idx_q     <= '0;
			k_q       <= '0;
			v_q       <= '0;
			used_q    <= '0;
			valid_q   <= '0;
			tf_q      <= '0;
			for (int p = 0; p < PROCESS_SLOTS; p++) begin
				cnt_q[p] <= '0;
				pf_q[p]  <= '0;
			end
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						granted_q <= '0;
						fault_q   <= 1'b0;
						state_q   <= S_DISP;
					end
				end
				S_DISP: begin
					k_q <= '0;
					unique case (cmd_q.op)
						OP_ALLOC: begin
							rem_q   <= cmd_q.pages;
							state_q <= (cmd_q.pages == '0) ? S_DONE : S_GSTART;
						end
						OP_FREE:   state_q <= S_FRD;
						OP_ACCESS: state_q <= div_start ? S_DIV : S_DONE;
						OP_NOP:    state_q <= S_DONE;
					endcase
				end
				S_GSTART: begin
					idx_q   <= '0;
					evict_q <= 1'b0;
					state_q <= (used_q < tot) ? S_FSCAN : S_ERD;
				end
				S_FSCAN: begin
					if (idx_q < tot) begin
						if (!valid_q[idx_q[FIDX_W-1:0]]) state_q <= S_TAKE;
						else idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_ERD: begin
					if (idx_q < tot) begin
						if (valid_q[idx_q[FIDX_W-1:0]]) state_q <= S_ECK;
						else idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_ECK: begin
					if (owner_rdata == cmd_q.pid) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_ERD;
					end else begin
						v_q     <= owner_rdata;
						k_q     <= '0;
						state_q <= S_LRD;
					end
				end
				S_LRD: begin
					if (k_q >= cnt_sel) begin
						evict_q <= 1'b1;
						state_q <= S_TAKE;
					end else begin
						state_q <= S_LCK;
					end
				end
				S_LCK: begin
					// found: the last entry moves into the hole
					if (list_rdata == idx_q[FIDX_W-1:0]) begin
						cnt_q[v_q] <= cnt_dec;
						state_q    <= S_TOWR;
					end else begin
						k_q     <= k_q + CNT_W'(1);
						state_q <= S_LRD;
					end
				end
				S_TOWR: begin
					evict_q <= 1'b1;
					state_q <= S_TAKE;
				end
				S_TAKE: begin
					// evicted frame stays in use, only its owner changes; if the grant fails, it is freed
					if (g_ok) begin
						valid_q[idx_q[FIDX_W-1:0]] <= 1'b1;
						if (!evict_q) used_q <= used_q + CNT_W'(1);
						cnt_q[cmd_q.pid] <= cnt_sel + CNT_W'(1);
					end else if (evict_q) begin
						valid_q[idx_q[FIDX_W-1:0]] <= 1'b0;
						if (used_q != '0) used_q <= used_q - CNT_W'(1);
					end
				end
				S_FRD: begin
					if (k_q >= cnt_sel) begin
						cnt_q[cmd_q.pid] <= '0;
						state_q          <= S_DONE;
					end else begin
						state_q <= S_FCK;
					end
				end
				S_FCK: begin
					if (valid_q[fr]) begin
						valid_q[fr] <= 1'b0;
						if (used_q != '0) used_q <= used_q - CNT_W'(1);
					end
					k_q     <= k_q + CNT_W'(1);
					state_q <= S_FRD;
				end
				S_DIV: begin
					if (div_done) begin
						fault_q          <= 1'b1;
						pf_q[cmd_q.pid]  <= pf_q[cmd_q.pid] + 32'd1;
						tf_q             <= tf_q + 32'd1;
						k_q              <= div_rem;
						state_q          <= S_AREL;
					end
				end
				S_AREL: begin
					if (valid_q[fr]) begin
						valid_q[fr] <= 1'b0;
						if (used_q != '0) used_q <= used_q - CNT_W'(1);
					end
					cnt_q[cmd_q.pid] <= cnt_dec;
					state_q          <= S_AMV;
				end
				S_AMV:  state_q <= S_GSTART;
				S_DONE: begin
					if (out_load) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// end of one frame grant
			if (g_end) begin
				if (cmd_q.op == OP_ALLOC) begin
					if (g_ok) begin
						granted_q <= granted_q + 7'd1;
						rem_q     <= rem_q - 7'd1;
					end
					state_q <= (!g_ok || rem_q == 7'd1) ? S_DONE : S_GSTART;
				end else begin
					granted_q <= {6'd0, g_ok};
					state_q   <= S_DONE;
				end
			end

			if (pool_clear) begin
				valid_q <= '0;
				used_q  <= '0;
				for (int p = 0; p < PROCESS_SLOTS; p++) begin
					cnt_q[p] <= '0;
				end
			end
		end
	end
endmodule

@@ rtl/page_frame_allocator_with_eviction_core.sv @@
// Page frame allocator: one result word per input word, in order. Work is
// done by a single sequencer, one item at a time; a two-word queue in front
// and an output register behind let input and output stall independently.
// Per item, from pickup to result: free releases each frame on the process's
// owned list; access without fault goes straight to the result, with fault
// it waits on the remainder unit, releases the chosen frame and makes one
// grant; allocate makes one grant per page. A grant scans the frame valid
// bits one a cycle up to the first free frame when one exists, otherwise it
// reads the owner of each used frame until a victim is found, searches the
// victim's owned list entry by entry and refills the hole, since list and
// owner tables sit in single-read-port memories. Writing the frame count
// register empties the pool at once; fault counters are kept.
module page_frame_allocator_with_eviction_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pfa_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output pfa_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data
);
	import pfa_pkg::*;

	logic [6:0] frames_q, thresh_q;
	logic       cmd_valid, cmd_pop, pool_clear;
	cmd_t       cmd;

	assign pool_clear = cfg_we && (cfg_index == CFG_FRAMES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FRAMES) frames_q <= cfg_data;
			if (cfg_index == CFG_THRESH) thresh_q <= cfg_data;
		end
	end

	pfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.thresh    (thresh_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	pfa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.frames_cfg (frames_q),
		.pool_clear (pool_clear),
		.out_valid  (out_valid),
		.out_item   (out_item),
		.out_stall  (out_stall)
	);
endmodule

@@ rtl/pfa_checker.sv @@
`include "assert_macros.svh"

module pfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input pfa_pkg::in_item_t  in_item,
	input logic               out_valid,
	input logic               out_stall,
	input pfa_pkg::out_item_t out_item
);
	import pfa_pkg::*;

	`PFA_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))
	`PFA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
	// a faulting access grants back at most one frame
	`PFA_ASSERT_IMP(a_fault_grant, out_valid && out_item.fault, out_item.granted_pages <= 7'd1)
	// free frames and frames of one process never exceed the pool
	`PFA_ASSERT_IMP(a_frame_sum, out_valid, (8'(out_item.free_frame_count) + 8'(out_item.owned_frame_count)) <= 8'(FRAME_SLOTS))
endmodule

bind page_frame_allocator_with_eviction_core pfa_checker u_pfa_checker (.*);
